[design/nwpt_pkg.sv]
`timescale 1ns / 1ps

package nwpt_pkg;

	localparam int ANGLE_W      = 18;
	localparam int IDX_W        = 8;
	localparam int CNT_W        = 9;
	localparam int DIST_W       = 21;
	localparam int INPUT_JOINTS = 6;
	localparam int COUNT_MIN    = 2;

	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		logic load_we;
		logic query_start;
		logic issue;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_issue;
		logic pipe_busy;
	} dp_status_t;

endpackage

[design/nwpt_ram.sv]
`timescale 1ns / 1ps

module nwpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[design/nwpt_ctrl.sv]
`timescale 1ns / 1ps

module nwpt_ctrl
	import nwpt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	assign cmd.load_we     = accept & ~func;
	assign cmd.query_start = accept & func;
	assign cmd.issue       = (state_q == ST_SCAN);
	assign cmd.finish      = (state_q == ST_DONE) & out_free;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.query_start) state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.last_issue) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[design/nwpt_dp.sv]
`timescale 1ns / 1ps

module nwpt_dp
	import nwpt_pkg::*;
#(
	parameter int MAX_POINTS  = 256,
	parameter int JOINT_COUNT = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output dp_status_t         status,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_count,
	input  logic [IDX_W-1:0]   point_slot,
	input  angle_t             joint_a,
	input  angle_t             joint_b,
	input  angle_t             joint_c,
	input  angle_t             joint_d,
	input  angle_t             joint_e,
	input  angle_t             joint_f,
	output logic [IDX_W-1:0]   goal_index,
	output logic [IDX_W-1:0]   goal_slot,
	output logic [DIST_W-1:0]  best_distance,
	output logic               turned_around,
	output logic               going_backward
);

	localparam int AW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SLOT_CAP = (MAX_POINTS < 256) ? MAX_POINTS : 256;
	localparam int ROW_W    = JOINT_COUNT * ANGLE_W;

	angle_t              in_joint [INPUT_JOINTS];
	angle_t              q_joint_q [JOINT_COUNT];
	logic [CNT_W-1:0]    point_count_q;
	logic [CNT_W-1:0]    n_eff;
	logic [CNT_W-1:0]    n_q;
	logic [IDX_W-1:0]    i_q;
	logic                rev_q;
	logic [IDX_W-1:0]    last_index_q;

	logic [AW+IDX_W-1:0] slot_ext;
	logic                slot_ok;
	logic [ROW_W-1:0]    wr_data;
	logic [ROW_W-1:0]    rd_data;
	logic [CNT_W-1:0]    phys;
	logic [AW+IDX_W-1:0] phys_ext;

	logic                v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]    idx_s1, idx_s2, idx_s3;
	logic [ANGLE_W-1:0]  abs_d [JOINT_COUNT];
	logic [ANGLE_W-1:0]  abs_s2 [JOINT_COUNT];
	logic [DIST_W-1:0]   sum_d;
	logic [DIST_W-1:0]   sum_s3;
	logic [DIST_W-1:0]   best_d_q;
	logic [IDX_W-1:0]    best_i_q;

	logic [CNT_W-1:0]    n_m1, n_m2;
	logic [IDX_W-1:0]    prev;
	logic                hit_end;
	logic [IDX_W-1:0]    sel_i, sel_prev, fin_i;
	logic                rev_nx;
	logic [CNT_W-1:0]    slot_nx;

	logic [IDX_W-1:0]    goal_index_q, goal_slot_q;
	logic [DIST_W-1:0]   best_distance_q;
	logic                turned_q, going_q;

	assign in_joint[0] = joint_a;
	assign in_joint[1] = joint_b;
	assign in_joint[2] = joint_c;
	assign in_joint[3] = joint_d;
	assign in_joint[4] = joint_e;
	assign in_joint[5] = joint_f;

	// config register and effective count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_W'(COUNT_MIN);
		end else if (cfg_we) begin
			point_count_q <= cfg_count;
		end
	end

	always_comb begin
		if (point_count_q < CNT_W'(COUNT_MIN)) begin
			n_eff = CNT_W'(COUNT_MIN);
		end else if (point_count_q > CNT_W'(SLOT_CAP)) begin
			n_eff = CNT_W'(SLOT_CAP);
		end else begin
			n_eff = point_count_q;
		end
	end

	// store write: one row per waypoint, extra joints stored as zero
	assign slot_ext = {{AW{1'b0}}, point_slot};
	assign slot_ok  = slot_ext < (AW+IDX_W)'(MAX_POINTS);

	always_comb begin
		for (int j = 0; j < JOINT_COUNT; j++) begin
			if (j < INPUT_JOINTS) begin
				wr_data[j*ANGLE_W +: ANGLE_W] = in_joint[j];
			end else begin
				wr_data[j*ANGLE_W +: ANGLE_W] = '0;
			end
		end
	end

	// scan address
	assign phys     = rev_q ? (n_q - CNT_W'(1) - {1'b0, i_q}) : {1'b0, i_q};
	assign phys_ext = {{AW{1'b0}}, phys[IDX_W-1:0]};

	nwpt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_POINTS)
	) u_store (
		.clk     (clk),
		.we      (cmd.load_we & slot_ok),
		.wr_addr (slot_ext[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (phys_ext[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			n_q <= n_eff;
			for (int j = 0; j < JOINT_COUNT; j++) begin
				if (j < INPUT_JOINTS) begin
					q_joint_q[j] <= in_joint[j];
				end else begin
					q_joint_q[j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.query_start) begin
			i_q <= '0;
		end else if (cmd.issue) begin
			i_q <= i_q + IDX_W'(1);
		end
	end

	assign status.last_issue = cmd.issue & ({1'b0, i_q} == n_q - CNT_W'(1));
	assign status.pipe_busy  = v_s1 | v_s2 | v_s3;

	// distance pipeline: row read, abs diffs, sum, compare
	always_comb begin
		for (int j = 0; j < JOINT_COUNT; j++) begin
			logic signed [ANGLE_W:0] diff;
			diff = {rd_data[j*ANGLE_W + ANGLE_W - 1], rd_data[j*ANGLE_W +: ANGLE_W]}
				- {q_joint_q[j][ANGLE_W-1], q_joint_q[j]};
			if (diff < 0) begin
				abs_d[j] = ANGLE_W'(-diff);
			end else begin
				abs_d[j] = ANGLE_W'(diff);
			end
		end
	end

	always_comb begin
		sum_d = '0;
		for (int j = 0; j < JOINT_COUNT; j++) begin
			sum_d = sum_d + DIST_W'(abs_s2[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= i_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		abs_s2 <= abs_d;
		sum_s3 <= sum_d;
		if (v_s3 && (idx_s3 == '0 || sum_s3 < best_d_q)) begin
			best_d_q <= sum_s3;
			best_i_q <= idx_s3;
		end
	end

	// progress rule
	assign n_m1     = n_q - CNT_W'(1);
	assign n_m2     = n_q - CNT_W'(2);
	assign prev     = ({1'b0, last_index_q} > n_m2) ? n_m2[IDX_W-1:0] : last_index_q;
	assign hit_end  = ({1'b0, best_i_q} == n_m1);
	assign sel_i    = hit_end ? '0 : best_i_q;
	assign sel_prev = hit_end ? '0 : prev;
	assign fin_i    = (sel_i < sel_prev) ? sel_prev : sel_i;
	assign rev_nx   = rev_q ^ hit_end;
	assign slot_nx  = rev_nx ? (n_m1 - {1'b0, fin_i}) : {1'b0, fin_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= '0;
			rev_q        <= 1'b0;
		end else if (cmd.finish) begin
			last_index_q <= fin_i;
			rev_q        <= rev_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			goal_index_q    <= fin_i + IDX_W'(1);
			goal_slot_q     <= slot_nx[IDX_W-1:0];
			best_distance_q <= best_d_q;
			turned_q        <= hit_end;
			going_q         <= rev_nx;
		end
	end

	assign goal_index     = goal_index_q;
	assign goal_slot      = goal_slot_q;
	assign best_distance  = best_distance_q;
	assign turned_around  = turned_q;
	assign going_backward = going_q;

endmodule

[design/nearest_waypoint_progress_tracker.sv]
// Nearest waypoint progress tracker. A load item (func 0) writes one waypoint of
// six joint angles into store slot point_slot. A query item (func 1) scans the
// point_count waypoints in traversal order, one store row per cycle with all
// joints compared in parallel, and returns one item with the goal waypoint index
// plus one, its store slot, the summed distance and the direction state. The
// scan is paced by the single read port of the waypoint store. The store is not
// cleared at reset: every slot a query can reach must be loaded first. The user
// must write point_count only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps

module nearest_waypoint_progress_tracker
	import nwpt_pkg::*;
#(
	parameter int MAX_POINTS  = 256,
	parameter int JOINT_COUNT = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CNT_W-1:0]   point_count,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [IDX_W-1:0]   point_slot,
	input  angle_t             joint_a,
	input  angle_t             joint_b,
	input  angle_t             joint_c,
	input  angle_t             joint_d,
	input  angle_t             joint_e,
	input  angle_t             joint_f,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [IDX_W-1:0]   goal_index,
	output logic [IDX_W-1:0]   goal_slot,
	output logic [DIST_W-1:0]  best_distance,
	output logic               turned_around,
	output logic               going_backward
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	nwpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	nwpt_dp #(
		.MAX_POINTS  (MAX_POINTS),
		.JOINT_COUNT (JOINT_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_count      (point_count),
		.point_slot     (point_slot),
		.joint_a        (joint_a),
		.joint_b        (joint_b),
		.joint_c        (joint_c),
		.joint_d        (joint_d),
		.joint_e        (joint_e),
		.joint_f        (joint_f),
		.goal_index     (goal_index),
		.goal_slot      (goal_slot),
		.best_distance  (best_distance),
		.turned_around  (turned_around),
		.going_backward (going_backward)
	);

`ifndef SYNTH
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func |=> in_stall)
		else $error("query item accepted without blocking the next item");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !func && !out_valid |=> !out_valid)
		else $error("load item produced a result");

	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> goal_index != '0)
		else $error("goal index of zero");

	a_finish_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !status.pipe_busy && !cmd.issue)
		else $error("result committed while scan still in flight");
`endif

endmodule
